### rtl/duty_cycle_alarm_decoder_top_defines.svh
// assertion macros for the duty cycle alarm decoder
`ifndef DUTY_CYCLE_ALARM_DECODER_TOP_DEFINES_SVH
`define DUTY_CYCLE_ALARM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DCAD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DCAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dcad_pkg.sv
// shared types and constants of the duty cycle alarm decoder
`default_nettype none

package dcad_pkg;

	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_REG_BITS  = 8;
	localparam int CLASS_BITS    = 3;

	localparam logic [1:0] REG_MIN_PERIOD      = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_PERIOD  = 2'd1;
	localparam logic [1:0] REG_ZERO_HIGH_LIMIT = 2'd2;

	localparam logic [CFG_REG_BITS-1:0] MIN_PERIOD_RST      = 8'd60;
	localparam logic [CFG_REG_BITS-1:0] TIMEOUT_PERIOD_RST  = 8'd135;
	localparam logic [CFG_REG_BITS-1:0] ZERO_HIGH_LIMIT_RST = 8'd2;

	localparam logic [CLASS_BITS-1:0] CLS_ZERO    = 3'd0;
	localparam logic [CLASS_BITS-1:0] CLS_NORMAL  = 3'd1;
	localparam logic [CLASS_BITS-1:0] CLS_FAULT_A = 3'd2;
	localparam logic [CLASS_BITS-1:0] CLS_FAULT_B = 3'd3;
	localparam logic [CLASS_BITS-1:0] CLS_FIRE    = 3'd4;
	localparam logic [CLASS_BITS-1:0] CLS_NONE    = 3'd7;

	typedef struct packed {
		logic [CFG_REG_BITS-1:0] min_period;
		logic [CFG_REG_BITS-1:0] timeout_period;
		logic [CFG_REG_BITS-1:0] zero_high_limit;
	} dcad_cfg_t;

	typedef struct packed {
		logic                  fault_relay;
		logic                  fire_relay;
		logic                  settled;
		logic [CLASS_BITS-1:0] duty_class;
		logic                  alarm_locked;
	} dcad_result_t;

endpackage

`default_nettype wire

### rtl/dcad_period.sv
// deglitch, edge detect, period and high counters, settlement decision
`default_nettype none

module dcad_period
	import dcad_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  sample,
	input  wire dcad_cfg_t             cfg,
	output logic                       settle,
	output logic [COUNT_BITS-1:0]      len,
	output logic [COUNT_BITS-1:0]      hi
);

	logic                  prev_raw_q;
	logic                  clean_q;
	logic                  prev_clean_q;
	logic                  locked_q;
	logic [COUNT_BITS-1:0] period_q;
	logic [COUNT_BITS-1:0] high_q;

	logic                  clean_n;
	logic                  rising;
	logic [COUNT_BITS-1:0] period_inc;
	logic [COUNT_BITS-1:0] high_inc;
	logic [COUNT_BITS-1:0] min_ext;
	logic [COUNT_BITS-1:0] tmo_ext;
	logic                  locked_n;
	logic [COUNT_BITS-1:0] period_n;
	logic [COUNT_BITS-1:0] high_n;

	always_comb begin
		clean_n    = (sample == prev_raw_q) ? sample : clean_q;
		rising     = clean_n && !prev_clean_q;
		period_inc = period_q + COUNT_BITS'(1);
		high_inc   = clean_n ? (high_q + COUNT_BITS'(1)) : high_q;
		min_ext    = COUNT_BITS'(cfg.min_period);
		tmo_ext    = COUNT_BITS'(cfg.timeout_period);
		settle     = 1'b0;
		len        = '0;
		hi         = '0;
		locked_n   = locked_q;
		period_n   = period_inc;
		high_n     = high_inc;
		if (rising) begin
			if (locked_q && (period_inc >= min_ext)) begin
				settle = 1'b1;
				len    = period_inc - COUNT_BITS'(1);
				hi     = high_inc - COUNT_BITS'(1);
			end
			locked_n = 1'b1;
			period_n = COUNT_BITS'(1);
			high_n   = COUNT_BITS'(1);
		end else if (period_inc >= tmo_ext) begin
			settle   = 1'b1;
			len      = period_inc;
			hi       = high_inc;
			locked_n = 1'b0;
			period_n = '0;
			high_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q   <= 1'b0;
			clean_q      <= 1'b0;
			prev_clean_q <= 1'b0;
			locked_q     <= 1'b0;
			period_q     <= '0;
			high_q       <= '0;
		end else if (advance) begin
			prev_raw_q   <= sample;
			clean_q      <= clean_n;
			prev_clean_q <= clean_n;
			locked_q     <= locked_n;
			period_q     <= period_n;
			high_q       <= high_n;
		end
	end

endmodule

`default_nettype wire

### rtl/dcad_alarm.sv
// duty classification, class confirmation and relay drive
`default_nettype none

module dcad_alarm
	import dcad_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  settle,
	input  wire logic [COUNT_BITS-1:0] len,
	input  wire logic [COUNT_BITS-1:0] hi,
	input  wire dcad_cfg_t             cfg,
	output dcad_result_t               result
);

	localparam int SUM_BITS = COUNT_BITS + 1;

	logic [CLASS_BITS-1:0] prev_class_q;
	logic [CLASS_BITS-1:0] conf_class_q;
	logic                  fire_q;
	logic [1:0]            relay_q;

	logic [SUM_BITS-1:0]   quarter;
	logic [SUM_BITS-1:0]   eighth;
	logic [SUM_BITS-1:0]   half;
	logic [SUM_BITS-1:0]   thr_normal;
	logic [SUM_BITS-1:0]   thr_fault_a;
	logic [SUM_BITS-1:0]   thr_fault_b;
	logic [SUM_BITS-1:0]   hi_ext;
	logic [SUM_BITS-1:0]   zero_ext;
	logic [CLASS_BITS-1:0] cls;
	logic                  confirm;
	logic [1:0]            relay_n;
	logic                  fire_n;

	always_comb begin
		quarter     = SUM_BITS'(len >> 2);
		eighth      = quarter >> 1;
		half        = SUM_BITS'(len >> 1);
		thr_normal  = quarter + eighth;
		thr_fault_a = half + eighth;
		thr_fault_b = half + quarter + eighth;
		hi_ext      = SUM_BITS'(hi);
		zero_ext    = SUM_BITS'(cfg.zero_high_limit);
		cls         = CLS_ZERO;
		if (settle) begin
			priority if (hi_ext <= zero_ext)    cls = CLS_ZERO;
			else if (hi_ext <= thr_normal)      cls = CLS_NORMAL;
			else if (hi_ext <= thr_fault_a)     cls = CLS_FAULT_A;
			else if (hi_ext <= thr_fault_b)     cls = CLS_FAULT_B;
			else                                cls = CLS_FIRE;
		end
		confirm = settle && !fire_q && (cls == prev_class_q) && (cls != conf_class_q);
		relay_n = relay_q;
		fire_n  = fire_q;
		if (confirm) begin
			priority if (cls == CLS_FIRE) begin
				relay_n = 2'b10;
				fire_n  = 1'b1;
			end else if (cls == CLS_NORMAL) begin
				relay_n = 2'b00;
			end else begin
				relay_n = 2'b01;
			end
		end
		result.fault_relay  = relay_n[0];
		result.fire_relay   = relay_n[1];
		result.settled      = settle;
		result.duty_class   = cls;
		result.alarm_locked = fire_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= CLS_NONE;
			conf_class_q <= CLS_NONE;
			fire_q       <= 1'b0;
			relay_q      <= 2'b00;
		end else if (advance) begin
			if (settle) begin
				prev_class_q <= cls;
			end
			if (confirm) begin
				conf_class_q <= cls;
			end
			fire_q  <= fire_n;
			relay_q <= relay_n;
		end
	end

endmodule

`default_nettype wire

### rtl/duty_cycle_alarm_decoder_top.sv
// top level of the duty cycle alarm decoder
// usage:
// input channel in_valid / in_stall carries one opto_sample per transaction,
// one sample tick each; the output channel out_valid / out_stall returns one
// transaction per sample with relay drive, settlement flag, duty class and
// the fire latch as they stand after that tick
// a sample is registered on acceptance and enters the output register, with
// out_valid, as it advances, which waits while out_stall holds a full output
// register; throughput one transaction per cycle while out_stall is low,
// with counter and class state updated between input and output registers
// when out_stall holds the output register, the input register still takes
// one more sample; in_stall rises only while both registers are full
// registers sit on an APB port at byte addresses 0, 4 and 8
// (min_period, timeout_period, zero_high_limit); pready is always high
// reset clears both registers' valid flags, the counters, the deglitch and
// edge state, the class history (none yet), the relays and the fire latch,
// and loads the register defaults 60, 135 and 2
`default_nettype none

`include "duty_cycle_alarm_decoder_top_defines.svh"

module duty_cycle_alarm_decoder_top
	import dcad_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [CFG_DATA_BITS-1:0] pwdata,
	output logic      [CFG_DATA_BITS-1:0] prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     opto_sample,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          fault_relay,
	output logic                          fire_relay,
	output logic                          settled,
	output logic      [CLASS_BITS-1:0]    duty_class,
	output logic                          alarm_locked
);

	dcad_cfg_t             cfg_q;
	logic                  valid_s1;
	logic                  sample_s1;
	logic                  out_valid_q;
	dcad_result_t          result_q;

	logic                  cfg_write;
	logic [1:0]            reg_idx;
	logic                  advance;
	logic                  accept;
	logic                  settle;
	logic [COUNT_BITS-1:0] len;
	logic [COUNT_BITS-1:0] hi;
	dcad_result_t          result_n;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_MIN_PERIOD:      prdata = CFG_DATA_BITS'(cfg_q.min_period);
			REG_TIMEOUT_PERIOD:  prdata = CFG_DATA_BITS'(cfg_q.timeout_period);
			REG_ZERO_HIGH_LIMIT: prdata = CFG_DATA_BITS'(cfg_q.zero_high_limit);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_period      <= MIN_PERIOD_RST;
			cfg_q.timeout_period  <= TIMEOUT_PERIOD_RST;
			cfg_q.zero_high_limit <= ZERO_HIGH_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_MIN_PERIOD:      cfg_q.min_period      <= pwdata[CFG_REG_BITS-1:0];
				REG_TIMEOUT_PERIOD:  cfg_q.timeout_period  <= pwdata[CFG_REG_BITS-1:0];
				REG_ZERO_HIGH_LIMIT: cfg_q.zero_high_limit <= pwdata[CFG_REG_BITS-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= opto_sample;
		end
		if (advance) begin
			result_q <= result_n;
		end
	end

	dcad_period #(
		.COUNT_BITS (COUNT_BITS)
	) u_period (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sample  (sample_s1),
		.cfg     (cfg_q),
		.settle  (settle),
		.len     (len),
		.hi      (hi)
	);

	dcad_alarm #(
		.COUNT_BITS (COUNT_BITS)
	) u_alarm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.settle  (settle),
		.len     (len),
		.hi      (hi),
		.cfg     (cfg_q),
		.result  (result_n)
	);

	assign out_valid    = out_valid_q;
	assign fault_relay  = result_q.fault_relay;
	assign fire_relay   = result_q.fire_relay;
	assign settled      = result_q.settled;
	assign duty_class   = result_q.duty_class;
	assign alarm_locked = result_q.alarm_locked;

	`DCAD_ASSERT_NOW(a_relays_exclusive, out_valid_q, !(fault_relay && fire_relay), "both relays closed")
	`DCAD_ASSERT_NOW(a_locked_fire, out_valid_q && alarm_locked, fire_relay, "latched alarm without fire relay")
	`DCAD_ASSERT_NOW(a_class_quiet, out_valid_q && !settled, duty_class == CLS_ZERO, "class without settlement")
	`DCAD_ASSERT_NEXT(a_latch_holds, out_valid_q && alarm_locked, alarm_locked, "alarm latch dropped")

endmodule

`default_nettype wire
